[rtl/core/ckhs_pkg.sv]
// ckhs_pkg: shared types, constants and helpers for the canonical k-mer hash sampler
// no dependencies; imported by every module of the block
package ckhs_pkg;

  localparam int MAX_K      = 31;
  localparam int KMER_W     = 2 * MAX_K;
  localparam int HASH_W     = 64;
  localparam int CHAR_W     = 8;
  localparam int KLEN_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = FIFO_AW + 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KMER_LENGTH      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_SEED        = 2'd2;

  localparam logic [KLEN_W-1:0] KLEN_RESET      = 5'd21;
  localparam logic [HASH_W-1:0] THRESHOLD_RESET = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [HASH_W-1:0] SEED_RESET      = 64'h0;

  // splitmix64 constants
  localparam logic [HASH_W-1:0] GOLDEN_ADD = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [HASH_W-1:0] MIX_MUL_A  = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [HASH_W-1:0] MIX_MUL_B  = 64'h94d0_49bb_1331_11eb;
  localparam int SHIFT_PRE  = 30;
  localparam int SHIFT_MID  = 27;
  localparam int SHIFT_POST = 31;

  typedef logic [KMER_W-1:0] kmer_t;
  typedef logic [HASH_W-1:0] hash_t;

  // front to queue
  typedef struct packed {
    logic  push;
    kmer_t canon;
  } push_t;

  // queue status
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // bit 2 set: not a base
  function automatic logic [2:0] decode_base(input logic [CHAR_W-1:0] ch);
    logic [2:0] code;
    case (ch) inside
      8'h41, 8'h61: code = 3'd0;   // A a
      8'h43, 8'h63: code = 3'd1;   // C c
      8'h47, 8'h67: code = 3'd2;   // G g
      8'h54, 8'h74: code = 3'd3;   // T t
      default:      code = 3'd4;
    endcase
    return code;
  endfunction

endpackage

[rtl/core/ckhs_in_if.sv]
// ckhs_in_if: input channel carrying one sequence character per word
// depends on ckhs_pkg
interface ckhs_in_if;
  import ckhs_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] base_char;
  modport source (output valid, output base_char, input ready);
  modport sink (input valid, input base_char, output ready);
endinterface

[rtl/core/ckhs_out_if.sv]
// ckhs_out_if: result channel carrying one sampled hash per word
// depends on ckhs_pkg
interface ckhs_out_if;
  import ckhs_pkg::*;
  logic              valid;
  logic              ready;
  logic [HASH_W-1:0] sampled_hash;
  modport source (output valid, output sampled_hash, input ready);
  modport sink (input valid, input sampled_hash, output ready);
endinterface

[rtl/core/ckhs_front.sv]
// ckhs_front: decodes characters, rolls forward and reverse-complement k-mers
// depends on ckhs_pkg and ckhs_in_if; pushes canonical k-mers to ckhs_fifo
module ckhs_front
  import ckhs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  ckhs_in_if.sink           in_ch,
  input  logic [KLEN_W-1:0] kmer_length,
  input  fifo_stat_t        fifo_stat,
  output push_t             push
);

  kmer_t             fwd_r, fwd_nxt;
  kmer_t             rc_r, rc_nxt;
  logic [KLEN_W-1:0] fill_r, fill_nxt;
  logic [KLEN_W-1:0] k_eff;
  logic [2:0]        code;
  logic [1:0]        comp;
  kmer_t             mask;
  logic [KLEN_W:0]   top;
  logic              accept;

  assign in_ch.ready = !fifo_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign code        = decode_base(in_ch.base_char);
  // complement base, 3 - code
  assign comp        = ~code[1:0];
  assign k_eff       = (kmer_length == '0) ? KLEN_W'(1) : kmer_length;
  assign mask        = ~({KMER_W{1'b1}} << {k_eff, 1'b0});
  assign top         = {k_eff - KLEN_W'(1), 1'b0};

  always_comb begin
    fwd_nxt = fwd_r;
    rc_nxt  = rc_r;
    fill_nxt = fill_r;
    push.push = 1'b0;
    if (accept) begin
      if (code[2]) begin
        fwd_nxt  = '0;
        rc_nxt   = '0;
        fill_nxt = '0;
      end else begin
        fwd_nxt = {fwd_r[KMER_W-3:0], code[1:0]} & mask;
        rc_nxt  = (rc_r >> 2) | (KMER_W'(comp) << top);
        if (fill_r < KLEN_W'(MAX_K)) begin
          fill_nxt = fill_r + KLEN_W'(1);
        end
        push.push = (fill_nxt >= k_eff);
      end
    end
    push.canon = (fwd_nxt < rc_nxt) ? fwd_nxt : rc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r  <= '0;
      rc_r   <= '0;
      fill_r <= '0;
    end else begin
      fwd_r  <= fwd_nxt;
      rc_r   <= rc_nxt;
      fill_r <= fill_nxt;
    end
  end

endmodule

[rtl/core/ckhs_fifo.sv]
// ckhs_fifo: short queue of canonical k-mers between front and hash back end
// depends on ckhs_pkg
module ckhs_fifo
  import ckhs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  push_t      push,
  input  logic       pop,
  output kmer_t      head,
  output fifo_stat_t stat
);

  kmer_t              mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, rp_r;
  logic [FIFO_CW-1:0] cnt_r;
  logic               do_push, do_pop;

  assign stat.full  = (cnt_r == FIFO_CW'(FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push.push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push.canon;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + FIFO_AW'(1);
      if (do_pop)  rp_r <= rp_r + FIFO_AW'(1);
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + FIFO_CW'(1);
        2'b01:   cnt_r <= cnt_r - FIFO_CW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

[rtl/core/ckhs_back.sv]
// ckhs_back: splitmix64 mixer on a shared 32x32 multiplier, threshold test, output register
// depends on ckhs_pkg and ckhs_out_if; pops canonical k-mers from ckhs_fifo
module ckhs_back
  import ckhs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  kmer_t      head,
  input  fifo_stat_t fifo_stat,
  output logic       pop,
  input  hash_t      sample_threshold,
  input  hash_t      hash_seed,
  ckhs_out_if.source out_ch
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PRE  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_POST = 3'd3;

  logic [2:0]  st_r, st_nxt;
  logic [1:0]  mstep_r, mstep_nxt;
  logic        round_r, round_nxt;
  hash_t       v_r, v_nxt;
  hash_t       opnd_r, opnd_nxt;
  hash_t       acc_r, acc_nxt;
  logic        out_valid_r, out_valid_nxt;
  hash_t       out_hash_r, out_hash_nxt;
  hash_t       mconst;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  hash_t       h;
  logic        out_free;

  assign mconst   = round_r ? MIX_MUL_B : MIX_MUL_A;
  assign prod     = mul_a * mul_b;
  assign h        = acc_r ^ (acc_r >> SHIFT_POST);
  assign out_free = !out_valid_r || out_ch.ready;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.sampled_hash = out_hash_r;

  // low 64 bits of a 64x64 product from three partial products
  always_comb begin
    case (mstep_r)
      2'd0:    begin mul_a = opnd_r[31:0];  mul_b = mconst[31:0];  end
      2'd1:    begin mul_a = opnd_r[31:0];  mul_b = mconst[63:32]; end
      default: begin mul_a = opnd_r[63:32]; mul_b = mconst[31:0];  end
    endcase
  end

  always_comb begin
    st_nxt        = st_r;
    mstep_nxt     = mstep_r;
    round_nxt     = round_r;
    v_nxt         = v_r;
    opnd_nxt      = opnd_r;
    acc_nxt       = acc_r;
    out_hash_nxt  = out_hash_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    pop           = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (!fifo_stat.empty) begin
          pop    = 1'b1;
          v_nxt  = ({2'b00, head} ^ hash_seed) + GOLDEN_ADD;
          st_nxt = ST_PRE;
        end
      end
      ST_PRE: begin
        opnd_nxt  = v_r ^ (v_r >> SHIFT_PRE);
        mstep_nxt = 2'd0;
        round_nxt = 1'b0;
        st_nxt    = ST_MUL;
      end
      ST_MUL: begin
        if (mstep_r == 2'd0) begin
          acc_nxt = prod;
        end else begin
          acc_nxt = {acc_r[63:32] + prod[31:0], acc_r[31:0]};
        end
        mstep_nxt = mstep_r + 2'd1;
        if (mstep_r == 2'd2) begin
          st_nxt = ST_POST;
        end
      end
      ST_POST: begin
        if (!round_r) begin
          opnd_nxt  = acc_r ^ (acc_r >> SHIFT_MID);
          round_nxt = 1'b1;
          mstep_nxt = 2'd0;
          st_nxt    = ST_MUL;
        end else if (h >= sample_threshold) begin
          st_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_hash_nxt  = h;
          st_nxt        = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    v_r        <= v_nxt;
    opnd_r     <= opnd_nxt;
    acc_r      <= acc_nxt;
    out_hash_r <= out_hash_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      mstep_r     <= '0;
      round_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      mstep_r     <= mstep_nxt;
      round_r     <= round_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/core/canonical_kmer_hash_sampler.sv]
// canonical_kmer_hash_sampler: top level, configuration registers and block wiring
// depends on ckhs_pkg, ckhs_in_if, ckhs_out_if, ckhs_front, ckhs_fifo, ckhs_back
//
// Takes one ASCII sequence character per input word. A/C/G/T in either case roll into
// a forward and a reverse-complement k-mer; any other byte clears both and the fill
// count. Once k bases have been seen, the smaller k-mer is XORed with hash_seed, mixed
// with splitmix64, and the hash goes out only if it is strictly below sample_threshold.
// The front end takes one character per cycle as long as its 4-entry queue has room;
// characters that make no complete k-mer cost nothing further. Each complete k-mer
// takes the back end through pop, premix, and two rounds of three partial products
// on one shared 32x32 multiplier plus a shift-xor step each; it works on one k-mer
// at a time, so that multiplier sets the sustained rate on long valid runs. A result
// sitting in the output register does not stop the queue from filling. The user must
// write configuration through cfg_we/cfg_index/cfg_wdata only while the block is idle, not enforced.
module canonical_kmer_hash_sampler
  import ckhs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  ckhs_in_if.sink              in_ch,
  ckhs_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [HASH_W-1:0]    cfg_wdata
);

  // configuration registers
  logic [KLEN_W-1:0] kmer_length_r;
  hash_t             sample_threshold_r;
  hash_t             hash_seed_r;

  // front/back decoupling
  push_t      push;
  fifo_stat_t fifo_stat;
  kmer_t      head;
  logic       pop;

  // register writes; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kmer_length_r      <= KLEN_RESET;
      sample_threshold_r <= THRESHOLD_RESET;
      hash_seed_r        <= SEED_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KMER_LENGTH:      kmer_length_r      <= cfg_wdata[KLEN_W-1:0];
        CFG_SAMPLE_THRESHOLD: sample_threshold_r <= cfg_wdata;
        CFG_HASH_SEED:        hash_seed_r        <= cfg_wdata;
        default:              ;
      endcase
    end
  end

  // character decode and rolling k-mers
  ckhs_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .kmer_length (kmer_length_r),
    .fifo_stat   (fifo_stat),
    .push        (push)
  );

  // canonical k-mer queue
  ckhs_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .stat  (fifo_stat)
  );

  // hash, threshold and output word
  ckhs_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .fifo_stat        (fifo_stat),
    .pop              (pop),
    .sample_threshold (sample_threshold_r),
    .hash_seed        (hash_seed_r),
    .out_ch           (out_ch)
  );

endmodule

[rtl/core/ckhs_checker.sv]
// ckhs_checker: port-level assertions on the sampler, bound to the top level
// depends on ckhs_pkg and canonical_kmer_hash_sampler
module ckhs_checker
  import ckhs_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [HASH_W-1:0]    out_hash,
  input logic                 cfg_we,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [HASH_W-1:0]    cfg_wdata
);

  // threshold as seen on the config port
  logic [HASH_W-1:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESHOLD_RESET;
    end else if (cfg_we && cfg_index == CFG_SAMPLE_THRESHOLD) begin
      thr_r <= cfg_wdata;
    end
  end

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_hold_hash: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_hash))
    else $error("result word changed while stalled");

  a_below_thr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hash < thr_r)
    else $error("emitted hash not below threshold");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

endmodule

bind canonical_kmer_hash_sampler ckhs_checker u_ckhs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_hash  (out_ch.sampled_hash),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index),
  .cfg_wdata (cfg_wdata)
);
